FILE: sv/bn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bn_pkg
// Shared widths, register indexes and types of the batch-norm inference block.
// ----------------------------------------------------------------------------
package bn_pkg;

    localparam int DATA_W   = 16;
    localparam int CHAN_W   = 8;
    localparam int CCOUNT_W = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int COEF_W   = 32;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_SIZE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON       = 2'd2;

    // item codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef logic signed [DATA_W-1:0] t_q88;
    typedef logic signed [COEF_W-1:0] t_coef;

endpackage
`default_nettype wire

FILE: sv/bn_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bn_in_if
// Input channel: load items and sample items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bn_in_if;
    import bn_pkg::*;

    logic                valid;
    logic                ready;
    logic                op;
    logic [CHAN_W-1:0]   channel;
    t_q88                sample;
    t_q88                gamma;
    t_q88                beta;
    t_q88                mean;
    logic [DATA_W-1:0]   variance;

    modport source (output valid, op, channel, sample, gamma, beta, mean, variance,
                    input ready);
    modport sink   (input valid, op, channel, sample, gamma, beta, mean, variance,
                    output ready);
endinterface
`default_nettype wire

FILE: sv/bn_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bn_out_if
// Output channel: normalized samples with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bn_out_if;
    import bn_pkg::*;

    logic valid;
    logic ready;
    t_q88 result;
    logic saturated;
    logic last_of_image;

    modport source (output valid, result, saturated, last_of_image, input ready);
    modport sink   (input valid, result, saturated, last_of_image, output ready);
endinterface
`default_nettype wire

FILE: sv/batch_norm_inference.sv
`default_nettype none
// ----------------------------------------------------------------------------
// batch_norm_inference
// Sample item: table read at accept, then multiply, then round and saturate into the
//   output register once it is free; the next item is accepted only after that.
// Load item: accept, 49 divide steps, 25 root steps, 3 multiply/write steps; the next
//   item is accepted only after the write.
// Reset clears counters, state and output valid and sets the configuration to 1;
//   the coefficient memory is not cleared and holds garbage until each channel is loaded.
// ----------------------------------------------------------------------------
module batch_norm_inference #(
    parameter int MAX_CHANNELS = 256
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [bn_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [bn_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    bn_in_if.sink                        i_in,
    bn_out_if.source                     o_out
);
    import bn_pkg::*;

    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CAP = (MAX_CHANNELS < 256) ? MAX_CHANNELS : 256;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SMUL  = 3'd1;
    localparam logic [2:0] ST_SOUT  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_SQRT  = 3'd4;
    localparam logic [2:0] ST_LMUL1 = 3'd5;
    localparam logic [2:0] ST_LMUL2 = 3'd6;
    localparam logic [2:0] ST_LFIN  = 3'd7;

    // configuration
    logic [CCOUNT_W-1:0] r_ccount;
    logic [DATA_W-1:0]   r_psize;
    logic [DATA_W-1:0]   r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ccount <= CCOUNT_W'(1);
            r_psize  <= DATA_W'(1);
            r_eps    <= DATA_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CHANNEL_COUNT: r_ccount <= i_cfg_data[CCOUNT_W-1:0];
                REG_PLANE_SIZE:    r_psize  <= i_cfg_data;
                REG_EPSILON:       r_eps    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [2:0] r_state, n_state;
    logic       accept;
    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    // position counters
    logic [CHAN_W-1:0] r_cpos, n_cpos;
    logic [DATA_W-1:0] r_ppos, n_ppos;
    logic [CCOUNT_W-1:0] nch;
    logic [DATA_W-1:0]   ps;
    logic [CHAN_W-1:0]   cp_cur;
    logic [DATA_W-1:0]   pp_cur;
    logic                last_cur;
    logic                plane_end;

    always_comb begin
        nch = r_ccount;
        if (nch == '0) nch = CCOUNT_W'(1);
        if (32'(nch) > CAP) nch = CCOUNT_W'(CAP);
        ps = (r_psize == '0) ? DATA_W'(1) : r_psize;
        pp_cur = (r_ppos >= ps) ? '0 : r_ppos;
        cp_cur = (CCOUNT_W'(r_cpos) >= nch) ? '0 : r_cpos;
        plane_end = (17'(pp_cur) + 17'd1 >= 17'(ps));
        last_cur = plane_end && (CCOUNT_W'(cp_cur) + CCOUNT_W'(1) >= nch);
        n_ppos = plane_end ? '0 : pp_cur + DATA_W'(1);
        n_cpos = cp_cur;
        if (plane_end) n_cpos = last_cur ? '0 : cp_cur + CHAN_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpos <= '0;
            r_ppos <= '0;
        end else if (accept && i_in.op == OP_SAMPLE) begin
            r_cpos <= n_cpos;
            r_ppos <= n_ppos;
        end
    end

    // coefficient memory: {scale, bias} per channel
    logic [2*COEF_W-1:0] r_mem [MAX_CHANNELS];
    logic [2*COEF_W-1:0] r_rdata;
    logic                mem_we;
    logic [AW-1:0]       r_waddr;
    logic [2*COEF_W-1:0] wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[r_waddr] <= wdata;
        if (accept && i_in.op == OP_SAMPLE) r_rdata <= r_mem[AW'(cp_cur)];
    end

    // sample path
    t_q88                r_x;
    logic                r_last;
    logic signed [47:0]  r_prod;
    t_coef               r_bias;
    logic signed [48:0]  acc;
    logic signed [32:0]  yw;
    t_q88                y_sat;
    logic                y_clip;

    always_comb begin
        acc = 49'(r_prod) + 49'($signed({r_bias, 8'd0}));
        yw  = 33'((acc + 49'sd32768) >>> 16);
        y_clip = 1'b1;
        if (yw > 33'sd32767)       y_sat = 16'sh7FFF;
        else if (yw < -33'sd32768) y_sat = 16'sh8000;
        else begin
            y_sat  = yw[15:0];
            y_clip = 1'b0;
        end
    end

    logic r_out_valid;
    logic out_free;
    t_q88 r_result;
    logic r_sat;
    logic r_last_out;
    assign out_free = !r_out_valid || o_out.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.result = r_result;
    assign o_out.saturated = r_sat;
    assign o_out.last_of_image = r_last_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_SOUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SOUT && out_free) begin
            r_result   <= y_sat;
            r_sat      <= y_clip;
            r_last_out <= r_last;
        end
    end

    // load path: divide 2^48 by v, then integer root, then fold
    t_q88               r_gamma, r_beta, r_mean;
    logic [24:0]        r_v;
    logic               r_wr_ok;
    logic [5:0]         r_cnt;
    logic [25:0]        r_rem;
    logic [48:0]        r_quot;
    logic [27:0]        r_srem;
    logic [24:0]        r_root;
    logic signed [41:0] r_gi;
    logic signed [31:0] r_gm;
    logic signed [57:0] r_gmi;

    logic [24:0] v_in;
    logic [25:0] div_sh;
    logic        div_ge;
    logic [49:0] n50;
    logic [27:0] sq_sh;
    logic [27:0] sq_trial;
    logic        sq_ge;
    logic signed [41:0] sc_r;
    logic signed [58:0] bs_diff;
    logic signed [42:0] bs_r;
    t_coef       scale_q, bias_q;

    always_comb begin
        v_in = {i_in.variance, 8'd0} + 25'(r_eps);
        if (v_in == '0) v_in = 25'd1;
        div_sh = {r_rem[24:0], (r_cnt == 6'd48)};
        div_ge = div_sh >= {1'b0, r_v};
        n50 = {1'b0, r_quot};
        sq_sh = {r_srem[25:0], n50[2*r_cnt[4:0] +: 2]};
        sq_trial = {1'b0, r_root, 2'b01};
        sq_ge = sq_sh >= sq_trial;

        sc_r = (r_gi + 42'sd128) >>> 8;
        if (sc_r > 42'sd2147483647)       scale_q = 32'sh7FFFFFFF;
        else if (sc_r < -42'sd2147483648) scale_q = 32'sh80000000;
        else                              scale_q = sc_r[31:0];

        bs_diff = $signed({r_beta, 24'd0}) - 59'(r_gmi);
        bs_r = 43'((bs_diff + 59'sd32768) >>> 16);
        if (bs_r > 43'sd2147483647)       bias_q = 32'sh7FFFFFFF;
        else if (bs_r < -43'sd2147483648) bias_q = 32'sh80000000;
        else                              bias_q = bs_r[31:0];

        wdata  = {scale_q, bias_q};
        mem_we = (r_state == ST_LFIN) && r_wr_ok;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x     <= i_in.sample;
            r_last  <= last_cur;
            r_gamma <= i_in.gamma;
            r_beta  <= i_in.beta;
            r_mean  <= i_in.mean;
            r_v     <= v_in;
            r_wr_ok <= 32'(i_in.channel) < 32'(MAX_CHANNELS);
            r_waddr <= AW'(i_in.channel);
            r_cnt   <= 6'd48;
            r_rem   <= '0;
            r_quot  <= '0;
        end
        unique case (r_state)
            ST_SMUL: begin
                r_prod <= 48'(r_x) * 48'($signed(r_rdata[2*COEF_W-1:COEF_W]));
                r_bias <= r_rdata[COEF_W-1:0];
            end
            ST_DIV: begin
                r_rem  <= div_ge ? div_sh - {1'b0, r_v} : div_sh;
                r_quot <= {r_quot[47:0], div_ge};
                if (r_cnt == '0) begin
                    r_cnt  <= 6'd24;
                    r_srem <= '0;
                    r_root <= '0;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
            ST_SQRT: begin
                r_srem <= sq_ge ? sq_sh - sq_trial : sq_sh;
                r_root <= {r_root[23:0], sq_ge};
                r_cnt  <= r_cnt - 6'd1;
            end
            ST_LMUL1: begin
                r_gi <= 42'(r_gamma) * 42'($signed({1'b0, r_root}));
                r_gm <= 32'(r_gamma) * 32'(r_mean);
            end
            ST_LMUL2: begin
                r_gmi <= 58'(r_gm) * 58'($signed({1'b0, r_root}));
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (accept) n_state = (i_in.op == OP_SAMPLE) ? ST_SMUL : ST_DIV;
            ST_SMUL:  n_state = ST_SOUT;
            ST_SOUT:  if (out_free) n_state = ST_IDLE;
            ST_DIV:   if (r_cnt == '0) n_state = ST_SQRT;
            ST_SQRT:  if (r_cnt == '0) n_state = ST_LMUL1;
            ST_LMUL1: n_state = ST_LMUL2;
            ST_LMUL2: n_state = ST_LFIN;
            ST_LFIN:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

endmodule
`default_nettype wire
